FILE: rtl/sequential_array_list_macros.svh
// Assertion macros shared by the list checker.
`ifndef SEQUENTIAL_ARRAY_LIST_MACROS_SVH
`define SEQUENTIAL_ARRAY_LIST_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SAL_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SAL_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/sal_pkg.sv
// Types, codes and sizes shared by the list controller and datapath.
package sal_pkg;

	localparam int DEPTH = 64;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int KW    = 32;
	localparam int PW    = 7;
	localparam int FW    = 3;
	localparam int SW    = 2;
	localparam int IW    = 6;

	localparam int IN_TDW  = 48;
	localparam int OUT_TDW = 48;

	localparam int IN_KEY_LSB = FW;
	localparam int IN_POS_LSB = FW + KW;

	typedef enum logic [FW-1:0] {
		FUNC_INSERT  = 3'd0,
		FUNC_DELETE  = 3'd1,
		FUNC_LSEARCH = 3'd2,
		FUNC_BSEARCH = 3'd3,
		FUNC_READ    = 3'd4,
		FUNC_CLEAR   = 3'd5
	} func_t;

	typedef enum logic [SW-1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISP,
		S_INS_RD,
		S_INS_WR,
		S_INS_PUT,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_DEL_RD,
		S_DEL_WR,
		S_BIN_RD,
		S_BIN_CHK,
		S_RD_RD,
		S_RD_CHK,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		ADDR_IDX,
		ADDR_IDX_M1,
		ADDR_IDX_P1,
		ADDR_MID,
		ADDR_POS
	} addr_sel_t;

	typedef enum logic {
		WD_RDATA,
		WD_KEY
	} wd_sel_t;

	typedef struct packed {
		logic      load;
		logic      idx_cnt;
		logic      idx_clr;
		logic      idx_inc;
		logic      idx_dec;
		logic      idx_mid;
		logic      bin_init;
		logic      lo_up;
		logic      hi_dn;
		logic      rd_en;
		addr_sel_t rsel;
		logic      wr_en;
		wd_sel_t   wsel;
		logic      cnt_inc;
		logic      cnt_dec;
		logic      cnt_clr;
		logic      res_set;
		status_t   res_status;
		logic      res_fidx;
		logic      res_rval;
		logic      out_load;
	} sal_cmd_t;

	typedef struct packed {
		func_t func;
		logic  ins_ok;
		logic  idx_gt_pos;
		logic  idx_lt_cnt;
		logic  pos_lt_cnt;
		logic  lo_le_hi;
		logic  key_eq;
		logic  key_lt;
		logic  out_free;
	} sal_stat_t;

endpackage

FILE: rtl/sequential_array_list.sv
// Top level of the packed signed-key list with insert, delete, search and read.
//
// Input channel (s_*): one item per operation; func selects insert, delete by key,
// linear search, binary search, read or clear, with key and position beside it.
// Output channel (m_*): exactly one result item per input item, in order, carrying
// status, found index, read value and the live count after the operation.
// Entries sit in a 64 x 32 RAM with one write and one registered read port; the
// controller walks it one entry per step. Clear, a bad code and a refused insert
// finish without touching the RAM; a linear search probes entries in order, a
// binary search makes at most 7 probes at 64 entries, an insert moves each entry
// above the position up, and a delete first scans as above and then moves each
// later entry down.
// One item is worked on at a time; s_tready is high only when the block is idle.
// The finished result waits in an output register, so the next item is accepted
// while the receiver stalls; work then holds at the end until that register frees.
// Reset clears the live count and the output valid; entries keep their contents
// (only slots below the count are ever read).
module sequential_array_list (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// func [2:0], key [34:3], position [41:35], zero [47:42]
	input  logic [sal_pkg::IN_TDW-1:0]  s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// status [1:0], found_index [7:2], read_value [39:8], entry_count [46:40], zero [47]
	output logic [sal_pkg::OUT_TDW-1:0] m_tdata
);

	import sal_pkg::*;

	sal_cmd_t  cmd;
	sal_stat_t stat;

	// Sequence each operation.
	sal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold operands, count, RAM and result register.
	sal_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

FILE: rtl/sal_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/sal_ctrl.sv
// Controller state machine that sequences each list operation.
module sal_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  sal_pkg::sal_stat_t stat,
	output sal_pkg::sal_cmd_t  cmd
);

	import sal_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (s_tvalid) state_d = S_DISP;
			S_DISP: begin
				unique case (stat.func)
					FUNC_INSERT:  state_d = stat.ins_ok ? S_INS_RD : S_FIN;
					FUNC_DELETE,
					FUNC_LSEARCH: state_d = S_SCAN_RD;
					FUNC_BSEARCH: state_d = S_BIN_RD;
					FUNC_READ:    state_d = S_RD_RD;
					default:      state_d = S_FIN;
				endcase
			end
			S_INS_RD:   state_d = stat.idx_gt_pos ? S_INS_WR : S_INS_PUT;
			S_INS_WR:   state_d = S_INS_RD;
			S_INS_PUT:  state_d = S_FIN;
			S_SCAN_RD:  state_d = stat.idx_lt_cnt ? S_SCAN_CHK : S_FIN;
			S_SCAN_CHK: begin
				if (!stat.key_eq) begin
					state_d = S_SCAN_RD;
				end else if (stat.func == FUNC_DELETE) begin
					state_d = S_DEL_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DEL_RD:   state_d = stat.idx_lt_cnt ? S_DEL_WR : S_FIN;
			S_DEL_WR:   state_d = S_DEL_RD;
			S_BIN_RD:   state_d = stat.lo_le_hi ? S_BIN_CHK : S_FIN;
			S_BIN_CHK:  state_d = stat.key_eq ? S_FIN : S_BIN_RD;
			S_RD_RD:    state_d = stat.pos_lt_cnt ? S_RD_CHK : S_FIN;
			S_RD_CHK:   state_d = S_FIN;
			S_FIN:      if (stat.out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			S_DISP: begin
				unique case (stat.func)
					FUNC_INSERT: begin
						cmd.idx_cnt    = stat.ins_ok;
						cmd.res_set    = !stat.ins_ok;
						cmd.res_status = ST_RANGE;
					end
					FUNC_DELETE,
					FUNC_LSEARCH: cmd.idx_clr = 1'b1;
					FUNC_BSEARCH: cmd.bin_init = 1'b1;
					FUNC_READ: ;
					FUNC_CLEAR: begin
						cmd.cnt_clr    = 1'b1;
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_OK;
					end
					default: begin
						cmd.res_set    = 1'b1;
						cmd.res_status = ST_RANGE;
					end
				endcase
			end
			S_INS_RD: begin
				cmd.rd_en = stat.idx_gt_pos;
				cmd.rsel  = ADDR_IDX_M1;
			end
			S_INS_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wsel    = WD_RDATA;
				cmd.idx_dec = 1'b1;
			end
			S_INS_PUT: begin
				cmd.wr_en      = 1'b1;
				cmd.wsel       = WD_KEY;
				cmd.cnt_inc    = 1'b1;
				cmd.res_set    = 1'b1;
				cmd.res_status = ST_OK;
			end
			S_SCAN_RD: begin
				cmd.rd_en      = stat.idx_lt_cnt;
				cmd.rsel       = ADDR_IDX;
				cmd.res_set    = !stat.idx_lt_cnt;
				cmd.res_status = ST_NOT_FOUND;
			end
			S_SCAN_CHK: begin
				if (!stat.key_eq) begin
					cmd.idx_inc = 1'b1;
				end else if (stat.func == FUNC_DELETE) begin
					cmd.cnt_dec = 1'b1;
				end else begin
					cmd.res_set    = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_fidx   = 1'b1;
				end
			end
			S_DEL_RD: begin
				cmd.rd_en      = stat.idx_lt_cnt;
				cmd.rsel       = ADDR_IDX_P1;
				cmd.res_set    = !stat.idx_lt_cnt;
				cmd.res_status = ST_OK;
			end
			S_DEL_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wsel    = WD_RDATA;
				cmd.idx_inc = 1'b1;
			end
			S_BIN_RD: begin
				cmd.rd_en      = stat.lo_le_hi;
				cmd.rsel       = ADDR_MID;
				cmd.idx_mid    = stat.lo_le_hi;
				cmd.res_set    = !stat.lo_le_hi;
				cmd.res_status = ST_NOT_FOUND;
			end
			S_BIN_CHK: begin
				cmd.res_set    = stat.key_eq;
				cmd.res_status = ST_OK;
				cmd.res_fidx   = 1'b1;
				cmd.lo_up      = !stat.key_eq && stat.key_lt;
				cmd.hi_dn      = !stat.key_eq && !stat.key_lt;
			end
			S_RD_RD: begin
				cmd.rd_en      = stat.pos_lt_cnt;
				cmd.rsel       = ADDR_POS;
				cmd.res_set    = !stat.pos_lt_cnt;
				cmd.res_status = ST_RANGE;
			end
			S_RD_CHK: begin
				cmd.res_set    = 1'b1;
				cmd.res_status = ST_OK;
				cmd.res_rval   = 1'b1;
			end
			S_FIN:    cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

endmodule

FILE: rtl/sal_dp.sv
// Datapath: operand, index, count and result registers around the entry RAM.
module sal_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [sal_pkg::IN_TDW-1:0]   s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sal_pkg::OUT_TDW-1:0]  m_tdata,
	input  sal_pkg::sal_cmd_t            cmd,
	output sal_pkg::sal_stat_t           stat
);

	import sal_pkg::*;

	func_t             func_q;
	logic [KW-1:0]     key_q;
	logic [PW-1:0]     pos_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic signed [CW:0] lo_q;
	logic signed [CW:0] hi_q;
	status_t           res_stat_q;
	logic [IW-1:0]     res_fidx_q;
	logic [KW-1:0]     res_rval_q;
	logic              out_valid_q;
	logic [OUT_TDW-1:0] out_data_q;

	logic [CW+1:0]     mid_sum;
	logic [AW-1:0]     mid_w;
	logic [AW-1:0]     raddr;
	logic [KW-1:0]     wdata;
	logic [KW-1:0]     rdata;

	assign mid_sum = {lo_q[CW], lo_q} + {hi_q[CW], hi_q};
	assign mid_w   = mid_sum[AW:1];

	always_comb begin
		case (cmd.rsel)
			ADDR_IDX:    raddr = idx_q[AW-1:0];
			ADDR_IDX_M1: raddr = AW'(idx_q - CW'(1));
			ADDR_IDX_P1: raddr = AW'(idx_q + CW'(1));
			ADDR_MID:    raddr = mid_w;
			default:     raddr = pos_q[AW-1:0];
		endcase
	end

	assign wdata = (cmd.wsel == WD_KEY) ? key_q : rdata;

	sal_ram #(
		.WIDTH (KW),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (idx_q[AW-1:0]),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Operands and work registers need no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func_t'(s_tdata[FW-1:0]);
			key_q  <= s_tdata[IN_KEY_LSB +: KW];
			pos_q  <= s_tdata[IN_POS_LSB +: PW];
		end
		if (cmd.idx_cnt) begin
			idx_q <= count_q;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end else if (cmd.idx_dec) begin
			idx_q <= idx_q - CW'(1);
		end else if (cmd.idx_mid) begin
			idx_q <= CW'(mid_w);
		end
		if (cmd.bin_init) begin
			lo_q <= '0;
			hi_q <= $signed({1'b0, count_q}) - $signed((CW+1)'(1));
		end else if (cmd.lo_up) begin
			lo_q <= $signed({1'b0, idx_q} + (CW+1)'(1));
		end else if (cmd.hi_dn) begin
			hi_q <= $signed({1'b0, idx_q} - (CW+1)'(1));
		end
		if (cmd.res_set) begin
			res_stat_q <= cmd.res_status;
			res_fidx_q <= cmd.res_fidx ? IW'(idx_q) : '0;
			res_rval_q <= cmd.res_rval ? rdata : '0;
		end
		if (cmd.out_load) begin
			out_data_q <= {1'b0, count_q, res_rval_q, res_fidx_q, res_stat_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.func       = func_q;
	assign stat.ins_ok     = (count_q < CW'(DEPTH)) && (pos_q <= count_q);
	assign stat.idx_gt_pos = idx_q > pos_q;
	assign stat.idx_lt_cnt = idx_q < count_q;
	assign stat.pos_lt_cnt = pos_q < count_q;
	assign stat.lo_le_hi   = lo_q <= hi_q;
	assign stat.key_eq     = rdata == key_q;
	assign stat.key_lt     = $signed(rdata) < $signed(key_q);
	assign stat.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

FILE: rtl/sal_chk.sv
// Port-level checker for the list block, bound to the top level.
`include "sequential_array_list_macros.svh"

module sal_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	`SAL_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
	`SAL_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "item accepted while busy")
	`SAL_ASSERT_IMP(a_count_range, m_tvalid, m_tdata[46:40] <= 7'd64, "entry count beyond depth")
	`SAL_ASSERT_IMP(a_fail_zero, m_tvalid && m_tdata[1:0] != 2'd0, m_tdata[39:2] == 38'd0, "failed result carries data")

endmodule

bind sequential_array_list sal_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
